### rtl/top_k_nearest_list_defines.svh
// ----------------------------------------------------------------------------
// top_k_nearest_list_defines.svh
// Assertion macros shared by the nearest-list RTL.
// ----------------------------------------------------------------------------
`ifndef TOP_K_NEAREST_LIST_DEFINES_SVH
`define TOP_K_NEAREST_LIST_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define TKN_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define TKN_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define TKN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tkn_pkg.sv
// ----------------------------------------------------------------------------
// tkn_pkg
// Types, codes and field layout of the nearest-candidate list.
// ----------------------------------------------------------------------------
package tkn_pkg;

    localparam int OP_W    = 2;
    localparam int KEY_W   = 64;
    localparam int DIN_W   = 16;
    localparam int RANK_W  = 6;
    localparam int CNT_OUT_W = 6;

    // Input word layout (s_tdata), lowest bit first
    localparam int IN_KEY_LSB  = 0;
    localparam int IN_DIST_LSB = IN_KEY_LSB + KEY_W;
    localparam int IN_RANK_LSB = IN_DIST_LSB + DIN_W;
    localparam int IN_DATA_W   = 88;

    // Output word layout (m_tdata), lowest bit first
    localparam int OUT_KEPT_LSB   = 0;
    localparam int OUT_PLACED_LSB = OUT_KEPT_LSB + 1;
    localparam int OUT_COUNT_LSB  = OUT_PLACED_LSB + RANK_W;
    localparam int OUT_VALID_LSB  = OUT_COUNT_LSB + CNT_OUT_W;
    localparam int OUT_KEY_LSB    = OUT_VALID_LSB + 1;
    localparam int OUT_DIST_LSB   = OUT_KEY_LSB + KEY_W;
    localparam int OUT_USED_W     = OUT_DIST_LSB + DIN_W;
    localparam int OUT_DATA_W     = 96;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } tkn_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } tkn_state_t;

    // Broadcast from the controller to every cell of the row
    typedef struct packed {
        logic              upd;
        logic              clr;
        logic [RANK_W-1:0] rank;
    } tkn_ctl_t;

endpackage

### rtl/tkn_cell.sv
// ----------------------------------------------------------------------------
// tkn_cell
// One slot of the sorted list: compares against the candidate, then holds,
// clears, takes the candidate, or takes its left neighbour's entry.
// ----------------------------------------------------------------------------
module tkn_cell #(
    parameter int DIST_BITS = 16,
    parameter int CELL_IDX  = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tkn_pkg::tkn_ctl_t       ctl,
    input  logic [63:0]             cand_key,
    input  logic [DIST_BITS-1:0]    cand_dist,
    input  logic                    prev_valid,
    input  logic                    prev_gt,
    input  logic [63:0]             prev_key,
    input  logic [DIST_BITS-1:0]    prev_dist,
    output logic                    valid,
    output logic                    gt,
    output logic                    take,
    output logic                    hit,
    output logic [63:0]             key,
    output logic [DIST_BITS-1:0]    slot_dist
);
    import tkn_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [KEY_W-1:0]     key_reg;
    logic [KEY_W-1:0]     key_next;
    logic [DIST_BITS-1:0] dist_reg;
    logic [DIST_BITS-1:0] dist_next;

    always_comb
    begin
        gt   = valid_reg && (dist_reg > cand_dist);
        // first slot that is farther, or the first empty slot
        take = !prev_gt && (gt || (prev_valid && !valid_reg));
        hit  = valid_reg && (int'(ctl.rank) == CELL_IDX);

        valid_next = valid_reg;
        key_next   = key_reg;
        dist_next  = dist_reg;
        if (ctl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.upd)
        begin
            if (prev_gt)
            begin
                // shift right by one slot
                valid_next = 1'b1;
                key_next   = prev_key;
                dist_next  = prev_dist;
            end
            else if (take)
            begin
                valid_next = 1'b1;
                key_next   = cand_key;
                dist_next  = cand_dist;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        dist_reg <= dist_next;
    end

    assign valid     = valid_reg;
    assign key       = key_reg;
    assign slot_dist = dist_reg;

endmodule

### rtl/top_k_nearest_list.sv
// ----------------------------------------------------------------------------
// top_k_nearest_list
// Sorted list of the LIST_DEPTH nearest candidates, one cell per slot.
// ----------------------------------------------------------------------------
// An accepted word is registered in the input registers and the block moves
// to the execute state, where the whole row of slot cells compares, shifts
// and inserts in one step and the result word is loaded into the output
// register. The block takes no new word until it is back in idle; a
// stalled output holds the item in the execute step until the result
// register is free. Inserts, reads at a rank and clears all cost the same.
// own_key is written through cfg_wr_en / cfg_wr_data; the user must do so
// only while the block is idle, which the block itself does not enforce.
module top_k_nearest_list #(
    parameter int LIST_DEPTH = 60,
    parameter int DIST_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,   // own_key
    input  logic        s_tvalid,
    output logic        s_tready,
    // cand_key[63:0], cand_distance[79:64], read_rank[85:80], zero[87:86]
    input  logic [tkn_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [1:0]  s_tuser,       // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // kept[0], placed_at[6:1], entry_count[12:7], entry_valid[13],
    // entry_key[77:14], entry_distance[93:78], zero[95:94]
    output logic [tkn_pkg::OUT_DATA_W-1:0] m_tdata
);
    import tkn_pkg::*;

    `include "top_k_nearest_list_defines.svh"

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    tkn_state_t           state_reg;
    tkn_state_t           state_next;
    logic                 fire;

    logic [KEY_W-1:0]     own_key_reg;
    tkn_op_t              op_reg;
    logic [KEY_W-1:0]     cand_key_reg;
    logic [DIST_BITS-1:0] cand_dist_reg;
    logic [RANK_W-1:0]    rank_reg;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic [OUT_DATA_W-1:0]     m_data_reg;
    logic [OUT_DATA_W-1:0]     m_data_next;

    tkn_ctl_t             ctl;
    logic                 full;
    logic                 drop;
    logic                 is_insert;
    logic                 is_read;

    logic [LIST_DEPTH-1:0] valid_vec;
    logic [LIST_DEPTH-1:0] gt_vec;
    logic [LIST_DEPTH-1:0] take_vec;
    logic [LIST_DEPTH-1:0] hit_vec;
    logic [KEY_W-1:0]      key_arr  [LIST_DEPTH];
    logic [DIST_BITS-1:0]  dist_arr [LIST_DEPTH];

    logic [IDX_W-1:0]      placed_idx;
    logic                  rd_valid;
    logic [KEY_W-1:0]      rd_key;
    logic [DIST_BITS-1:0]  rd_dist;

    // ---------------- control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        fire       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold until the result register can take the word
                if (!m_valid_reg || m_tready)
                begin
                    fire       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_key_reg <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                own_key_reg <= cfg_wr_data;
            end
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg        <= tkn_op_t'(s_tuser);
            cand_key_reg  <= s_tdata[IN_KEY_LSB +: KEY_W];
            cand_dist_reg <= DIST_BITS'(s_tdata[IN_DIST_LSB +: DIN_W]);
            rank_reg      <= s_tdata[IN_RANK_LSB +: RANK_W];
        end
        if (fire)
        begin
            m_data_reg <= m_data_next;
        end
    end

    // ---------------- decision ----------------
    always_comb
    begin
        is_insert = (op_reg == OP_INSERT);
        is_read   = (op_reg == OP_READ);
        full      = valid_vec[LIST_DEPTH-1];
        drop      = (cand_key_reg == own_key_reg)
                    || (full && (cand_dist_reg >= dist_arr[LIST_DEPTH-1]));

        ctl.upd  = fire && is_insert && !drop;
        ctl.clr  = fire && (op_reg == OP_CLEAR);
        ctl.rank = rank_reg;

        count_next = count_reg;
        if (ctl.clr)
        begin
            count_next = '0;
        end
        else if (ctl.upd && !full)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end

        m_valid_next = m_valid_reg;
        if (fire)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    // ---------------- cell row ----------------
    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        logic                 p_valid;
        logic                 p_gt;
        logic [KEY_W-1:0]     p_key;
        logic [DIST_BITS-1:0] p_dist;

        if (i == 0)
        begin : g_head
            assign p_valid = 1'b1;
            assign p_gt    = 1'b0;
            assign p_key   = cand_key_reg;
            assign p_dist  = cand_dist_reg;
        end
        else
        begin : g_body
            assign p_valid = valid_vec[i-1];
            assign p_gt    = gt_vec[i-1];
            assign p_key   = key_arr[i-1];
            assign p_dist  = dist_arr[i-1];
        end

        tkn_cell #(
            .DIST_BITS (DIST_BITS),
            .CELL_IDX  (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .cand_key   (cand_key_reg),
            .cand_dist  (cand_dist_reg),
            .prev_valid (p_valid),
            .prev_gt    (p_gt),
            .prev_key   (p_key),
            .prev_dist  (p_dist),
            .valid      (valid_vec[i]),
            .gt         (gt_vec[i]),
            .take       (take_vec[i]),
            .hit        (hit_vec[i]),
            .key        (key_arr[i]),
            .slot_dist  (dist_arr[i])
        );
    end

    // ---------------- result gather ----------------
    always_comb
    begin
        placed_idx = '0;
        rd_valid   = 1'b0;
        rd_key     = '0;
        rd_dist    = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (take_vec[i])
            begin
                placed_idx = placed_idx | IDX_W'(i);
            end
            if (hit_vec[i])
            begin
                rd_valid = 1'b1;
                rd_key   = rd_key | key_arr[i];
                rd_dist  = rd_dist | dist_arr[i];
            end
        end

        m_data_next = '0;
        m_data_next[OUT_COUNT_LSB +: CNT_OUT_W] = CNT_OUT_W'(count_next);
        if (is_insert && !drop)
        begin
            m_data_next[OUT_KEPT_LSB]                = 1'b1;
            m_data_next[OUT_PLACED_LSB +: RANK_W]    = RANK_W'(placed_idx);
        end
        if (is_read && rd_valid)
        begin
            m_data_next[OUT_VALID_LSB]               = 1'b1;
            m_data_next[OUT_KEY_LSB +: KEY_W]        = rd_key;
            m_data_next[OUT_DIST_LSB +: DIN_W]       = DIN_W'(rd_dist);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------- checks ----------------
    `TKN_ASSERT_ALWAYS(a_valid_thermo,
        ((valid_vec & (valid_vec + 1'b1)) == '0), "slot valid bits not contiguous")
    `TKN_ASSERT_ALWAYS(a_count_match,
        ($countones(valid_vec) == int'(count_reg)), "count disagrees with valid slots")
    `TKN_ASSERT_SAME(a_one_take,
        ctl.upd, $onehot(take_vec), "insert must land in exactly one slot")
    `TKN_ASSERT_NEXT(a_clear_empty,
        ctl.clr, (count_reg == '0 && valid_vec == '0), "clear left entries behind")
    `TKN_ASSERT_SAME(a_fire_free,
        fire, (!m_valid_reg || m_tready), "result overwritten before taken")

endmodule

### tb/top_k_nearest_list_test.sv
// ----------------------------------------------------------------------------
// top_k_nearest_list_test
// Self-checking bench for the sorted nearest-candidate list.
// ----------------------------------------------------------------------------
// A queue of pending words feeds a clocked stream driver. Every accepted word
// runs through a local model of the sorted list, and the expected reply goes
// into a queue. A clocked monitor compares each reply with the oldest one
// waiting. own_key is rewritten between phases while the block is idle, and
// the back-pressure profile changes from phase to phase.
module top_k_nearest_list_test;
    import tkn_pkg::*;

    localparam int LIST_DEPTH  = 60;
    localparam int DIST_BITS   = 16;
    localparam logic [15:0] DIST_MASK = 16'((32'd1 << DIST_BITS) - 1);
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        tkn_op_t     op;
        logic [63:0] key;
        logic [15:0] distance;
        logic [5:0]  rank;
    } cand_word_t;

    typedef struct packed {
        logic        kept;
        logic [5:0]  placed_at;
        logic [5:0]  entry_count;
        logic        entry_valid;
        logic [63:0] entry_key;
        logic [15:0] entry_distance;
    } list_reply_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [63:0]           cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // local copy of the list
    logic [63:0] list_keys [LIST_DEPTH];
    logic [15:0] list_dists [LIST_DEPTH];
    int          list_count;
    logic [63:0] own_key_mdl;

    cand_word_t  pending_words [$];
    list_reply_t expected_replies [$];
    cand_word_t  word_on_bus;
    list_reply_t seen_reply;
    list_reply_t want_reply;

    int send_idle_pct = 27;
    int recv_idle_pct = 48;
    int hold_left = 0;
    int replies_seen = 0;
    int mismatches = 0;
    int cycle_count = 0;

    int n_kept = 0, n_dropped = 0, n_own = 0, n_none = 0;
    int n_hit = 0, n_miss = 0, n_clears = 0, peak_count = 0;

    top_k_nearest_list #(
        .LIST_DEPTH (LIST_DEPTH),
        .DIST_BITS  (DIST_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // cand_key, cand_distance, read_rank, zero pad
        .s_tuser     (s_tuser),     // operation
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)      // kept, placed_at, entry_count, entry_valid,
                                    // entry_key, entry_distance, zero pad
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // Apply one word to the list and return the reply it should cause.
    function automatic list_reply_t predict_reply(cand_word_t w);
        list_reply_t r;
        int          i;
        logic        full;
        logic [15:0] d;
        r = '0;
        d = w.distance & DIST_MASK;
        case (w.op)
            OP_INSERT:
            begin
                full = (list_count == LIST_DEPTH);
                if (w.key == own_key_mdl)
                    n_own++;
                else if (full && d >= list_dists[LIST_DEPTH-1])
                    n_dropped++;
                else
                begin
                    if (full)
                        i = LIST_DEPTH - 1;
                    else
                    begin
                        i = list_count;
                        list_count++;
                    end
                    // shift farther-than-candidate entries up by one
                    while (i > 0 && list_dists[i-1] > d)
                    begin
                        list_keys[i]  = list_keys[i-1];
                        list_dists[i] = list_dists[i-1];
                        i--;
                    end
                    list_keys[i]  = w.key;
                    list_dists[i] = d;
                    r.kept        = 1'b1;
                    r.placed_at   = 6'(i);
                    n_kept++;
                end
            end
            OP_READ:
            begin
                if (w.rank < list_count)
                begin
                    r.entry_valid    = 1'b1;
                    r.entry_key      = list_keys[w.rank];
                    r.entry_distance = list_dists[w.rank];
                    n_hit++;
                end
                else
                    n_miss++;
            end
            OP_CLEAR:
            begin
                list_count = 0;
                n_clears++;
            end
            default:
                n_none++;
        endcase
        if (list_count > peak_count)
            peak_count = list_count;
        r.entry_count = 6'(list_count);
        return r;
    endfunction

    function automatic cand_word_t make_word(tkn_op_t op, logic [63:0] key,
                                             logic [15:0] distance, logic [5:0] rank);
        cand_word_t w;
        w.op       = op;
        w.key      = key;
        w.distance = distance;
        w.rank     = rank;
        return w;
    endfunction

    function automatic cand_word_t rand_word(tkn_op_t op);
        return make_word(op, {$urandom, $urandom}, 16'($urandom_range(65535)),
                         6'($urandom_range(63)));
    endfunction

    // Stream driver: advance to the next pending word once the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= OP_INSERT;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_replies.push_back(predict_reply(word_on_bus));
            if (!s_tvalid || s_tready)
            begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    word_on_bus = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, word_on_bus.rank, word_on_bus.distance,
                                 word_on_bus.key};
                    s_tuser  <= word_on_bus.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Reply monitor and receiver back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                replies_seen++;
                seen_reply.kept           = m_tdata[OUT_KEPT_LSB];
                seen_reply.placed_at      = m_tdata[OUT_PLACED_LSB +: RANK_W];
                seen_reply.entry_count    = m_tdata[OUT_COUNT_LSB +: CNT_OUT_W];
                seen_reply.entry_valid    = m_tdata[OUT_VALID_LSB];
                seen_reply.entry_key      = m_tdata[OUT_KEY_LSB +: KEY_W];
                seen_reply.entry_distance = m_tdata[OUT_DIST_LSB +: DIN_W];
                if (expected_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reply %0d with nothing expected: %p", replies_seen,
                                 seen_reply);
                end
                else
                begin
                    want_reply = expected_replies.pop_front();
                    if (seen_reply !== want_reply)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("reply %0d mismatch", replies_seen);
                            $display("  want kept=%0d at=%0d cnt=%0d vld=%0d key=%h dist=%h",
                                     want_reply.kept, want_reply.placed_at,
                                     want_reply.entry_count, want_reply.entry_valid,
                                     want_reply.entry_key, want_reply.entry_distance);
                            $display("  got  kept=%0d at=%0d cnt=%0d vld=%0d key=%h dist=%h",
                                     seen_reply.kept, seen_reply.placed_at,
                                     seen_reply.entry_count, seen_reply.entry_valid,
                                     seen_reply.entry_key, seen_reply.entry_distance);
                        end
                    end
                end
                // hold off for a long stretch so the block backs up into its input
                if (replies_seen == 120 || replies_seen == 380)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_own_key(input logic [63:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        own_key_mdl = value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || s_tvalid || expected_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One run: usually a clear, then mostly inserts with reads and noise mixed in.
    task automatic queue_run(input int room, output int queued);
        int          n_inserts;
        int          spread;
        int          pick;
        int          i;
        logic [15:0] d;
        queued = 0;
        if ($urandom_range(9) < 7)
        begin
            pending_words.push_back(rand_word(OP_CLEAR));
            queued++;
        end
        n_inserts = $urandom_range(30, 90);
        if (n_inserts > room)
            n_inserts = room;
        spread    = $urandom_range(2);
        for (i = 0; i < n_inserts; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                pending_words.push_back(rand_word(OP_READ));
            else if (pick < 13)
                pending_words.push_back(make_word(OP_INSERT, own_key_mdl,
                                                  16'($urandom), 6'($urandom)));
            else if (pick < 15)
                pending_words.push_back(rand_word(OP_NONE));
            else if (pick < 17)
                pending_words.push_back(rand_word(OP_CLEAR));
            else
            begin
                case (spread)
                    0: d = 16'($urandom_range(65535));
                    1: d = 16'($urandom_range(7));
                    default: d = $urandom_range(1) ? 16'hFFFF - 16'($urandom_range(15))
                                                   : 16'($urandom_range(15));
                endcase
                pending_words.push_back(make_word(OP_INSERT, {$urandom, $urandom}, d,
                                                  6'($urandom)));
            end
            queued++;
        end
        for (i = 0; i < 4; i++)
        begin
            pending_words.push_back(rand_word(OP_READ));
            queued++;
        end
    endtask

    task automatic queue_phase(input int n_words);
        int total;
        int got;
        int room;
        total = 0;
        while (total < n_words)
        begin
            room = n_words - total - 5;
            if (room < 1)
                room = 1;
            queue_run(room, got);
            total += got;
        end
    endtask

    initial
    begin
        int r;
        list_count  = 0;
        own_key_mdl = '0;
        for (r = 0; r < LIST_DEPTH; r++)
        begin
            list_keys[r]  = '0;
            list_dists[r] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, own key at its top value
        write_own_key('1);
        pending_words.push_back(make_word(OP_READ, '0, '0, 6'd0));
        pending_words.push_back(make_word(OP_INSERT, '0, 16'hFFFF, 6'd63));
        pending_words.push_back(make_word(OP_INSERT, '1, 16'd5, 6'd0));
        pending_words.push_back(make_word(OP_INSERT, 64'h0123_4567_89AB_CDEF, 16'h0000, 6'd0));
        pending_words.push_back(make_word(OP_INSERT, 64'hA5A5_A5A5_A5A5_A5A5, 16'hFFFF, 6'd0));
        pending_words.push_back(make_word(OP_INSERT, 64'h5A5A_5A5A_5A5A_5A5A, 16'h8000, 6'd0));
        pending_words.push_back(make_word(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFE, 16'h0000, 6'd0));
        for (r = 0; r < 6; r++)
            pending_words.push_back(make_word(OP_READ, '1, 16'hFFFF, 6'(r)));
        pending_words.push_back(make_word(OP_READ, '0, '0, 6'd63));
        pending_words.push_back(make_word(OP_NONE, '1, 16'hFFFF, 6'd63));
        pending_words.push_back(make_word(OP_CLEAR, '1, 16'hFFFF, 6'd63));
        pending_words.push_back(make_word(OP_READ, '0, '0, 6'd0));
        pending_words.push_back(rand_word(OP_INSERT));
        pending_words.push_back(make_word(OP_READ, '0, '0, 6'd0));
        wait_idle();

        write_own_key('0);
        queue_phase(143);
        wait_idle();

        send_idle_pct = 48;
        recv_idle_pct = 27;
        write_own_key({$urandom, $urandom});
        queue_phase(143);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_own_key({$urandom, $urandom});
        queue_phase(143);
        wait_idle();
        repeat (10) @(posedge clk);

        if (expected_replies.size() != 0)
        begin
            mismatches += expected_replies.size();
            $display("%0d replies never arrived", expected_replies.size());
        end
        $display("%0d replies checked: %0d kept, %0d dropped, %0d own key, %0d no-op",
                 replies_seen, n_kept, n_dropped, n_own, n_none);
        $display("reads %0d in range, %0d beyond count; %0d clears; peak %0d of %0d",
                 n_hit, n_miss, n_clears, peak_count, LIST_DEPTH);
        if (mismatches == 0)
            $display("simulation ok");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/tkn_pkg.sv
rtl/tkn_cell.sv
rtl/top_k_nearest_list.sv
tb/top_k_nearest_list_test.sv
